FILE: rtl/sdfd_pkg.sv
// Shared types and constants of the skip/copy delta frame decoder.
// Used by the front, the back and the top level; depends on nothing else.
package sdfd_pkg;

   localparam int DEFAULT_MAX_WIDTH  = 2048;
   localparam int DEFAULT_MAX_HEIGHT = 2048;

   // Configuration register indexes and reset values.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_PITCH    = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_COUNT  = 2'd3;

   localparam logic [11:0] RESET_FRAME_WIDTH  = 12'd640;
   localparam logic [11:0] RESET_FRAME_HEIGHT = 12'd480;
   localparam logic [12:0] RESET_ROW_PITCH    = 13'd640;
   localparam logic [15:0] RESET_FRAME_COUNT  = 16'd1;

   // Kinds of work that the front hands to the back.
   localparam logic OP_SKIP = 1'b0;
   localparam logic OP_LIT  = 1'b1;

   typedef struct packed {
      logic [11:0] frame_width;
      logic [11:0] frame_height;
      logic [12:0] row_pitch;
      logic [15:0] frame_count;
   } cfg_type;

   typedef struct packed {
      logic       kind;
      logic       last;
      logic [7:0] data;
   } op_type;

   // Outcome of a skip, reported back to the front.
   typedef struct packed {
      logic valid;
      logic ended;
   } skip_resolve_type;

   typedef struct packed {
      logic [23:0] pixel_address;
      logic [10:0] pixel_column;
      logic [10:0] pixel_row;
      logic [7:0]  color_index;
      logic        write_enable;
      logic        frame_done;
      logic [15:0] frame_number;
   } result_type;

endpackage

FILE: rtl/sdfd_fifo.sv
// Small first-in first-out queue held in flip-flops.
// Generic over width and depth; uses no package.
module sdfd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_data = store_ff[rd_ptr_ff];
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         store_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

FILE: rtl/sdfd_front.sv
// Front of the decoder: accepts coded bytes and sorts them into skips and literals.
// Depends on sdfd_pkg; waits on the back to learn how each skip ended.
module sdfd_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  logic [7:0]                data_byte,
   output logic                      full,
   output logic                      op_push,
   output sdfd_pkg::op_type          op_data,
   input  logic                      op_full,
   input  sdfd_pkg::skip_resolve_type resolve
);
   import sdfd_pkg::*;

   localparam logic [1:0] PH_SKIP  = 2'd0;
   localparam logic [1:0] PH_COUNT = 2'd1;
   localparam logic [1:0] PH_LIT   = 2'd2;

   logic [1:0] phase_ff, phase_in;
   logic [7:0] lit_left_ff, lit_left_in;
   logic       waiting_ff, waiting_in;
   logic       accept;
   logic       last_lit;

   assign full     = waiting_ff || op_full;
   assign accept   = push && !full;
   assign last_lit = (lit_left_ff <= 8'd1);

   always_comb begin
      phase_in      = phase_ff;
      lit_left_in   = lit_left_ff;
      waiting_in    = waiting_ff;
      op_push       = 1'b0;
      op_data.kind  = OP_LIT;
      op_data.last  = last_lit;
      op_data.data  = data_byte;
      if (resolve.valid) begin
         // A skip that closed the frame leaves the next byte a skip count.
         waiting_in = 1'b0;
         phase_in   = resolve.ended ? PH_SKIP : PH_COUNT;
      end else if (accept) begin
         unique case (phase_ff)
            PH_SKIP: begin
               op_push      = 1'b1;
               op_data.kind = OP_SKIP;
               waiting_in   = 1'b1;
            end
            PH_COUNT: begin
               if (data_byte == 8'd0) begin
                  phase_in = PH_SKIP;
               end else begin
                  lit_left_in = data_byte;
                  phase_in    = PH_LIT;
               end
            end
            default: begin
               op_push = 1'b1;
               if (lit_left_ff != 8'd0) begin
                  lit_left_in = lit_left_ff - 8'd1;
               end
               if (last_lit) begin
                  phase_in = PH_SKIP;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_SKIP;
         lit_left_ff <= '0;
         waiting_ff  <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         lit_left_ff <= lit_left_in;
         waiting_ff  <= waiting_in;
      end
   end

endmodule

FILE: rtl/sdfd_back.sv
// Back of the decoder: keeps the raster position and frame index and forms results.
// Depends on sdfd_pkg; takes work from the op queue, writes the result queue.
module sdfd_back #(
   parameter int MAX_WIDTH  = sdfd_pkg::DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = sdfd_pkg::DEFAULT_MAX_HEIGHT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  sdfd_pkg::cfg_type          cfg,
   input  logic                       op_empty,
   input  sdfd_pkg::op_type           op_data,
   output logic                       op_pop,
   output logic                       res_push,
   output sdfd_pkg::result_type       res_data,
   input  logic                       res_full,
   output sdfd_pkg::skip_resolve_type resolve
);
   import sdfd_pkg::*;

   localparam int W_W    = $clog2(MAX_WIDTH + 1);
   localparam int H_W    = $clog2(MAX_HEIGHT + 1);
   localparam int COL_W  = $clog2(MAX_WIDTH + 256);
   localparam int ROW_W  = H_W;
   localparam int PROD_W = ROW_W + 13;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_WRAP = 1'b1;

   logic             state_ff, state_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [15:0]      frame_ff, frame_in;

   logic [W_W-1:0]    w_eff;
   logic [H_W-1:0]    h_eff;
   logic              in_frame;
   logic [COL_W:0]    col_inc;
   logic [COL_W-1:0]  lit_col;
   logic [ROW_W-1:0]  lit_row;
   logic              lit_done;
   logic [16:0]       frame_plus;
   logic [15:0]       frame_wrap;
   logic [PROD_W-1:0] prod;
   logic [PROD_W:0]   addr_sum;
   result_type        lit_res;

   // Zero sizes count as one; sizes above the limits saturate.
   always_comb begin
      if (cfg.frame_width == '0) begin
         w_eff = W_W'(1);
      end else if (cfg.frame_width > MAX_WIDTH) begin
         w_eff = W_W'(MAX_WIDTH);
      end else begin
         w_eff = W_W'(cfg.frame_width);
      end
      if (cfg.frame_height == '0) begin
         h_eff = H_W'(1);
      end else if (cfg.frame_height > MAX_HEIGHT) begin
         h_eff = H_W'(MAX_HEIGHT);
      end else begin
         h_eff = H_W'(cfg.frame_height);
      end
   end

   assign in_frame   = (row_ff < h_eff);
   assign col_inc    = {1'b0, col_ff} + 1'b1;
   assign frame_plus = {1'b0, frame_ff} + 17'd1;
   assign frame_wrap = (frame_plus >= {1'b0, cfg.frame_count}) ? 16'd0 : frame_plus[15:0];
   assign prod       = PROD_W'(row_ff * cfg.row_pitch);
   assign addr_sum   = {1'b0, prod} + (PROD_W + 1)'(col_ff);

   // Position after a literal: step one column, wrapping into the next row.
   always_comb begin
      lit_col = col_ff;
      lit_row = row_ff;
      if (in_frame) begin
         if (col_inc >= w_eff) begin
            lit_col = '0;
            lit_row = row_ff + 1'b1;
         end else begin
            lit_col = col_inc[COL_W-1:0];
         end
      end
   end

   assign lit_done = op_data.last && (lit_row >= h_eff);

   // Literals past the last row keep only their color and frame fields; the pixel fields are zeroed.
   always_comb begin
      lit_res.color_index  = op_data.data;
      lit_res.frame_done   = lit_done;
      lit_res.frame_number = frame_ff;
      if (in_frame) begin
         lit_res.pixel_address = 24'(addr_sum);
         lit_res.pixel_column  = 11'(col_ff);
         lit_res.pixel_row     = 11'(row_ff);
         lit_res.write_enable  = col_ff[0] | row_ff[0];
      end else begin
         lit_res.pixel_address = '0;
         lit_res.pixel_column  = '0;
         lit_res.pixel_row     = '0;
         lit_res.write_enable  = 1'b0;
      end
   end

   always_comb begin
      state_in  = state_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      frame_in  = frame_ff;
      op_pop    = 1'b0;
      res_push  = 1'b0;
      res_data  = lit_res;
      resolve   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!op_empty) begin
               if (op_data.kind == OP_LIT) begin
                  if (!res_full) begin
                     op_pop   = 1'b1;
                     res_push = 1'b1;
                     if (lit_done) begin
                        col_in   = '0;
                        row_in   = '0;
                        frame_in = frame_wrap;
                     end else begin
                        col_in = lit_col;
                        row_in = lit_row;
                     end
                  end
               end else begin
                  op_pop   = 1'b1;
                  col_in   = col_ff + COL_W'(op_data.data);
                  state_in = ST_WRAP;
               end
            end
         end
         default: begin
            // One row is wrapped per cycle until the column fits.
            if ((col_ff >= w_eff) && in_frame) begin
               col_in = col_ff - COL_W'(w_eff);
               row_in = row_ff + 1'b1;
            end else if (!in_frame) begin
               if (!res_full) begin
                  res_push              = 1'b1;
                  res_data              = '0;
                  res_data.frame_done   = 1'b1;
                  res_data.frame_number = frame_ff;
                  col_in                = '0;
                  row_in                = '0;
                  frame_in              = frame_wrap;
                  resolve.valid         = 1'b1;
                  resolve.ended         = 1'b1;
                  state_in              = ST_IDLE;
               end
            end else begin
               resolve.valid = 1'b1;
               state_in      = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         col_ff   <= '0;
         row_ff   <= '0;
         frame_ff <= '0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         frame_ff <= frame_in;
      end
   end

endmodule

FILE: rtl/skip_copy_delta_frame_decoder_unit.sv
// Top level of the skip/copy delta frame decoder.
// Depends on sdfd_pkg, sdfd_fifo, sdfd_front and sdfd_back.

// The decoder reads a byte stream of delta-coded frames, each a run of groups made of a
// skip count, a literal count and that many palette-index bytes, and produces one pixel
// item per literal byte plus one frame-done item for a skip that runs off the last row.
// Bytes enter through a push/full queue interface and items leave through an empty/pop
// queue interface; configuration registers are to be written through the csr_ port only
// while the block is idle, and the block itself does not enforce this. For a skip byte,
// the back wraps the column by one subtraction of the frame width per cycle, and the
// front holds off further bytes until the back has decided whether the skip closed the
// frame. The back pops a literal and pushes its item in the same cycle; with a two-entry
// op queue and a two-entry result queue, a stalled consumer does not stop the front
// until both queues fill. Palette conversion to 15 or 16 bit color happens downstream.
module skip_copy_delta_frame_decoder_unit #(
   parameter int MAX_WIDTH  = sdfd_pkg::DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = sdfd_pkg::DEFAULT_MAX_HEIGHT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   output logic                             req_full,
   input  logic [7:0]                       req_data_byte,
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output logic [23:0]                      rsp_pixel_address,
   output logic [10:0]                      rsp_pixel_column,
   output logic [10:0]                      rsp_pixel_row,
   output logic [7:0]                       rsp_color_index,
   output logic                             rsp_write_enable,
   output logic                             rsp_frame_done,
   output logic [15:0]                      rsp_frame_number,
   input  logic                             csr_write_enable,
   input  logic [sdfd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sdfd_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import sdfd_pkg::*;

   localparam int OP_W  = $bits(op_type);
   localparam int RES_W = $bits(result_type);

   cfg_type          cfg_ff;
   op_type           op_in_data, op_out_data;
   logic             op_push, op_full, op_empty, op_pop;
   result_type       res_in_data, res_out_data;
   logic             res_push, res_full;
   skip_resolve_type resolve;

   // Configuration registers; each keeps only its own width of the write data.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width  <= RESET_FRAME_WIDTH;
         cfg_ff.frame_height <= RESET_FRAME_HEIGHT;
         cfg_ff.row_pitch    <= RESET_ROW_PITCH;
         cfg_ff.frame_count  <= RESET_FRAME_COUNT;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  cfg_ff.frame_width  <= csr_write_data[11:0];
            CSR_FRAME_HEIGHT: cfg_ff.frame_height <= csr_write_data[11:0];
            CSR_ROW_PITCH:    cfg_ff.row_pitch    <= csr_write_data[12:0];
            default:          cfg_ff.frame_count  <= csr_write_data[15:0];
         endcase
      end
   end

   // The front classifies bytes and keeps track of the group structure.
   sdfd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .data_byte (req_data_byte),
      .full      (req_full),
      .op_push   (op_push),
      .op_data   (op_in_data),
      .op_full   (op_full),
      .resolve   (resolve)
   );

   // Work waiting for the back.
   sdfd_fifo #(
      .WIDTH (OP_W),
      .DEPTH (2)
   ) u_op_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (op_push),
      .wr_data (op_in_data),
      .full    (op_full),
      .rd_en   (op_pop),
      .rd_data (op_out_data),
      .empty   (op_empty)
   );

   // The back owns column, row and frame index and forms each item.
   sdfd_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .op_empty (op_empty),
      .op_data  (op_out_data),
      .op_pop   (op_pop),
      .res_push (res_push),
      .res_data (res_in_data),
      .res_full (res_full),
      .resolve  (resolve)
   );

   // Finished items wait here until the consumer pops them.
   sdfd_fifo #(
      .WIDTH (RES_W),
      .DEPTH (2)
   ) u_result_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (res_push),
      .wr_data (res_in_data),
      .full    (res_full),
      .rd_en   (rsp_pop),
      .rd_data (res_out_data),
      .empty   (rsp_empty)
   );

   assign rsp_pixel_address = res_out_data.pixel_address;
   assign rsp_pixel_column  = res_out_data.pixel_column;
   assign rsp_pixel_row     = res_out_data.pixel_row;
   assign rsp_color_index   = res_out_data.color_index;
   assign rsp_write_enable  = res_out_data.write_enable;
   assign rsp_frame_done    = res_out_data.frame_done;
   assign rsp_frame_number  = res_out_data.frame_number;

endmodule

FILE: bench/skip_copy_delta_frame_decoder_unit_tb.sv
// Self-checking testbench for the skip/copy delta frame decoder.
// Depends on sdfd_pkg and skip_copy_delta_frame_decoder_unit; reads no files.
module skip_copy_delta_frame_decoder_unit_tb;
   import sdfd_pkg::*;

   // The decoder runs with its default frame limits.
   localparam int unsigned MAX_WIDTH  = DEFAULT_MAX_WIDTH;
   localparam int unsigned MAX_HEIGHT = DEFAULT_MAX_HEIGHT;

   // A skip can wrap up to a whole frame of rows at one row per cycle, for instance when
   // the width shrinks under a wide column. The quiet time before a register write covers
   // that with margin.
   localparam int SETTLE_CYCLES = 3000;
   localparam int LONG_HOLD     = 400;
   localparam int PHASE_ITEMS   = 240;
   localparam int STALL_HEAVY   = 82;
   localparam int STALL_LIGHT   = 14;
   localparam int CYCLE_LIMIT   = 2000000;

   typedef enum logic [1:0] {DEC_SKIP, DEC_COUNT, DEC_LITERAL} dec_phase_type;
   typedef enum logic {ROW_BYTE, ROW_CSR} row_kind_type;

   // One row of the directed stimulus. It is either a register write or a coded byte.
   // A byte row may carry a typed-in pixel item that replaces the predicted one.
   typedef struct packed {
      row_kind_type           kind;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  value;
      logic [7:0]             data;
      logic                   typed;
      result_type             pixel;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_push = 1'b0;
   logic                   req_full;
   logic [7:0]             req_data_byte = '0;
   logic                   rsp_empty;
   logic                   rsp_pop = 1'b0;
   logic [23:0]            rsp_pixel_address;
   logic [10:0]            rsp_pixel_column;
   logic [10:0]            rsp_pixel_row;
   logic [7:0]             rsp_color_index;
   logic                   rsp_write_enable;
   logic                   rsp_frame_done;
   logic [15:0]            rsp_frame_number;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data = '0;

   // Register copies and decoder state of the predictor. They start at their reset values.
   logic [11:0]   cfg_width  = RESET_FRAME_WIDTH;
   logic [11:0]   cfg_height = RESET_FRAME_HEIGHT;
   logic [12:0]   cfg_pitch  = RESET_ROW_PITCH;
   logic [15:0]   cfg_frames = RESET_FRAME_COUNT;
   dec_phase_type dec_phase  = DEC_SKIP;
   int unsigned   lits_left  = 0;
   int unsigned   cur_col    = 0;
   int unsigned   cur_row    = 0;
   int unsigned   cur_frame  = 0;

   result_type   pending_pixels[$];
   stim_row_type stim_rows[$];
   int           error_count = 0;
   int           cycle_count = 0;
   int           send_idle_pct = 0;
   int           recv_stall_pct = 0;
   // The main process raises hold_requests. The receiver process serves each request
   // with one long stretch of no popping, which it counts down itself.
   int           hold_requests = 0;
   int           hold_served = 0;
   int           hold_left = 0;

   skip_copy_delta_frame_decoder_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_data_byte     (req_data_byte),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_pixel_address (rsp_pixel_address),
      .rsp_pixel_column  (rsp_pixel_column),
      .rsp_pixel_row     (rsp_pixel_row),
      .rsp_color_index   (rsp_color_index),
      .rsp_write_enable  (rsp_write_enable),
      .rsp_frame_done    (rsp_frame_done),
      .rsp_frame_number  (rsp_frame_number),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   always #5 clock = ~clock;

   // A zero size counts as one, and a size above the frame limit is clipped to it.
   function automatic int unsigned limit_dim(input logic [11:0] v, input int unsigned top);
      if (v == 0) return 1;
      if (v > top) return top;
      return v;
   endfunction

   // The decoder returns to the top left corner. The frame index wraps at the frame
   // count, and a count of zero behaves like one.
   function automatic void close_frame();
      cur_col   = 0;
      cur_row   = 0;
      dec_phase = DEC_SKIP;
      lits_left = 0;
      if (cur_frame + 1 >= cfg_frames) cur_frame = 0;
      else cur_frame = (cur_frame + 1) & 16'hFFFF;
   endfunction

   // Decodes one coded byte and advances the predicted state. The return value is 1
   // when the byte gives a pixel item, and that item is placed in pix.
   function automatic bit decode_byte(input logic [7:0] b, output result_type pix);
      int unsigned w;
      int unsigned h;
      int unsigned addr;
      bit          produced;
      w        = limit_dim(cfg_width, MAX_WIDTH);
      h        = limit_dim(cfg_height, MAX_HEIGHT);
      pix      = '0;
      produced = 1'b0;
      case (dec_phase)
         DEC_SKIP: begin
            cur_col += b;
            while (cur_col >= w && cur_row < h) begin
               cur_col -= w;
               cur_row++;
            end
            if (cur_row >= h) begin
               // The skip ran off the last row. One frame-done item with zeroed
               // pixel fields is produced.
               pix.frame_done   = 1'b1;
               pix.frame_number = cur_frame[15:0];
               close_frame();
               produced = 1'b1;
            end else begin
               dec_phase = DEC_COUNT;
            end
         end
         DEC_COUNT: begin
            if (b == 0) begin
               dec_phase = DEC_SKIP;
            end else begin
               lits_left = b;
               dec_phase = DEC_LITERAL;
            end
         end
         default: begin
            pix.color_index  = b;
            pix.frame_number = cur_frame[15:0];
            if (cur_row < h) begin
               addr               = cur_row * cfg_pitch + cur_col;
               pix.pixel_address  = addr[23:0];
               pix.pixel_column   = cur_col[10:0];
               pix.pixel_row      = cur_row[10:0];
               pix.write_enable   = cur_col[0] | cur_row[0];
               cur_col++;
               if (cur_col >= w) begin
                  cur_col = 0;
                  cur_row++;
               end
            end
            // Literals past the last row are consumed, but they write nothing.
            if (lits_left > 0) lits_left--;
            if (lits_left == 0) begin
               dec_phase = DEC_SKIP;
               if (cur_row >= h) begin
                  pix.frame_done = 1'b1;
                  close_frame();
               end
            end
            produced = 1'b1;
         end
      endcase
      return produced;
   endfunction

   function automatic void add_byte(input logic [7:0] b);
      stim_row_type r;
      r      = '0;
      r.kind = ROW_BYTE;
      r.data = b;
      stim_rows.push_back(r);
   endfunction

   function automatic void add_pixel(input logic [7:0] b, input logic [23:0] addr,
                                     input logic [10:0] col, input logic [10:0] row,
                                     input logic [7:0] color, input logic we,
                                     input logic done, input logic [15:0] frame);
      stim_row_type r;
      r                     = '0;
      r.kind                = ROW_BYTE;
      r.data                = b;
      r.typed               = 1'b1;
      r.pixel.pixel_address = addr;
      r.pixel.pixel_column  = col;
      r.pixel.pixel_row     = row;
      r.pixel.color_index   = color;
      r.pixel.write_enable  = we;
      r.pixel.frame_done    = done;
      r.pixel.frame_number  = frame;
      stim_rows.push_back(r);
   endfunction

   function automatic void add_csr(input logic [CSR_INDEX_W-1:0] idx,
                                   input logic [CSR_DATA_W-1:0] val);
      stim_row_type r;
      r       = '0;
      r.kind  = ROW_CSR;
      r.index = idx;
      r.value = val;
      stim_rows.push_back(r);
   endfunction

   // Offers one byte and returns at the edge that accepts it, with push still high.
   // The item is predicted when it is offered. That is safe because it stays offered
   // until it is taken, and no result can appear before the expectation is queued.
   task automatic send_byte(input logic [7:0] b, input bit typed, input result_type typed_pix);
      result_type predicted;
      bit         produced;
      csr_write_enable <= 1'b0;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push      <= 1'b1;
      req_data_byte <= b;
      produced = decode_byte(b, predicted);
      if (typed) pending_pixels.push_back(typed_pix);
      else if (produced) pending_pixels.push_back(predicted);
      @(posedge clock);
      while (req_full) @(posedge clock);
   endtask

   // Stops offering and waits until every expected item has come back. It then waits
   // out any skip that is still wrapping rows without producing an item.
   task automatic settle();
      req_push         <= 1'b0;
      csr_write_enable <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Back-to-back writes keep the enable high. The next byte or settle lowers it.
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= val;
      @(posedge clock);
      case (idx)
         CSR_FRAME_WIDTH:  cfg_width  = val[11:0];
         CSR_FRAME_HEIGHT: cfg_height = val[11:0];
         CSR_ROW_PITCH:    cfg_pitch  = val[12:0];
         CSR_FRAME_COUNT:  cfg_frames = val[15:0];
         default: ;
      endcase
   endtask

   // One group is a skip count, a literal count and the literal bytes. Its sizes are
   // drawn relative to the row width, so that skips wrap rows and frames end often.
   // A few groups begin with a stray byte, which shifts the decoder off the grouping.
   task automatic send_group(inout int sent);
      int unsigned w;
      int unsigned span;
      int unsigned pick;
      int unsigned skip;
      int unsigned count;
      w    = limit_dim(cfg_width, MAX_WIDTH);
      span = (2 * w < 255) ? 2 * w : 255;
      if ($urandom_range(0, 99) < 5) begin
         send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
         sent++;
      end
      pick = $urandom_range(0, 99);
      if (pick < 10) skip = 0;
      else if (pick < 70) skip = $urandom_range(0, span);
      else if (pick < 90) skip = $urandom_range(0, 255);
      else skip = 255;
      send_byte(8'(skip), 1'b0, '0);
      sent++;
      // If the skip closed the frame, the next byte is a skip again.
      if (dec_phase != DEC_COUNT) return;
      pick = $urandom_range(0, 99);
      if (pick < 15) count = 0;
      else if (pick < 65) count = $urandom_range(1, 8);
      else if (pick < 90) count = $urandom_range(1, (span + 2 < 255) ? span + 2 : 255);
      else count = $urandom_range(0, 255);
      send_byte(8'(count), 1'b0, '0);
      sent++;
      repeat (count) begin
         send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
         sent++;
      end
   endtask

   // One random phase runs under one setting of all four registers and one idling
   // mode. Halfway through, the sender pauses until everything has drained.
   task automatic run_phase(input int unsigned w, h, p, c, input int send_pct, recv_pct,
                            input bit pressure);
      int sent;
      bit paused;
      settle();
      write_csr(CSR_FRAME_WIDTH, 16'(w));
      write_csr(CSR_FRAME_HEIGHT, 16'(h));
      write_csr(CSR_ROW_PITCH, 16'(p));
      write_csr(CSR_FRAME_COUNT, 16'(c));
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      sent   = 0;
      paused = 1'b0;
      if (pressure) begin
         // The receiver holds off while a long literal run keeps arriving. The two
         // internal queues fill up, and full must hold the sender back.
         hold_requests++;
         send_byte(8'd0, 1'b0, '0);
         send_byte(8'd60, 1'b0, '0);
         repeat (60) send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
         sent += 62;
      end
      while (sent < PHASE_ITEMS) begin
         if (!paused && sent >= PHASE_ITEMS / 2) begin
            settle();
            paused = 1'b1;
         end
         send_group(sent);
      end
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         error_count++;
      end
   endtask

   // Receiver. It pops at random according to the current stall rate. When asked, it
   // holds off for one long stretch of cycles.
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left   = LONG_HOLD;
         rsp_pop <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // Checker. At each edge that pops an item, the item's fields are compared with the
   // oldest expectation. All values are sampled as they stood before the edge.
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_pixels.size() == 0) begin
            $error("result item with no expectation waiting: address %0h frame %0h",
                   rsp_pixel_address, rsp_frame_number);
            error_count++;
         end else begin
            want = pending_pixels.pop_front();
            compare_field("pixel_address", want.pixel_address, rsp_pixel_address);
            compare_field("pixel_column", want.pixel_column, rsp_pixel_column);
            compare_field("pixel_row", want.pixel_row, rsp_pixel_row);
            compare_field("color_index", want.color_index, rsp_color_index);
            compare_field("write_enable", want.write_enable, rsp_write_enable);
            compare_field("frame_done", want.frame_done, rsp_frame_done);
            compare_field("frame_number", want.frame_number, rsp_frame_number);
         end
      end
   end

   // Watchdog. The limit is far above the slowest correct run.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $error("run exceeded %0d cycles", CYCLE_LIMIT);
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      bit dirty;
      dirty = 1'b0;

      // Default registers (640 by 480, pitch 640, one frame). The first literals land
      // at the top left corner. The skips stay inside row zero.
      add_byte(8'd0);
      add_byte(8'd2);
      add_pixel(8'h00, 24'd0, 11'd0, 11'd0, 8'h00, 1'b0, 1'b0, 16'd0);
      add_pixel(8'hFF, 24'd1, 11'd1, 11'd0, 8'hFF, 1'b1, 1'b0, 16'd0);
      add_byte(8'd255);
      add_byte(8'd0);
      add_byte(8'd255);
      add_byte(8'd1);
      add_pixel(8'h5A, 24'd512, 11'd512, 11'd0, 8'h5A, 1'b0, 1'b0, 16'd0);
      // Zero width, zero pitch and a zero frame count. With column 513 and a width of
      // one, the next skip runs off the two-row frame.
      add_csr(CSR_FRAME_WIDTH, 16'd0);
      add_csr(CSR_FRAME_HEIGHT, 16'd2);
      add_csr(CSR_ROW_PITCH, 16'd0);
      add_csr(CSR_FRAME_COUNT, 16'd0);
      add_pixel(8'd0, 24'd0, 11'd0, 11'd0, 8'h00, 1'b0, 1'b1, 16'd0);
      add_byte(8'd0);
      add_byte(8'd3);
      add_pixel(8'h11, 24'd0, 11'd0, 11'd0, 8'h11, 1'b0, 1'b0, 16'd0);
      add_pixel(8'h22, 24'd0, 11'd0, 11'd1, 8'h22, 1'b1, 1'b0, 16'd0);
      // The third literal lies past the last row. It writes nothing and ends the frame.
      add_pixel(8'h33, 24'd0, 11'd0, 11'd0, 8'h33, 1'b0, 1'b1, 16'd0);
      // Sizes above the frame limits, with the largest pitch and frame count.
      add_csr(CSR_FRAME_WIDTH, 16'd4095);
      add_csr(CSR_FRAME_HEIGHT, 16'd4095);
      add_csr(CSR_ROW_PITCH, 16'd8191);
      add_csr(CSR_FRAME_COUNT, 16'd65535);
      add_byte(8'd255);
      add_byte(8'd2);
      add_byte(8'h80);
      add_byte(8'h01);
      // A one-row frame of width 3 and two frames. Both frame endings are shown: one
      // by a skip, then one by a literal run that overruns the row.
      add_csr(CSR_FRAME_WIDTH, 16'd3);
      add_csr(CSR_FRAME_HEIGHT, 16'd1);
      add_csr(CSR_ROW_PITCH, 16'd5);
      add_csr(CSR_FRAME_COUNT, 16'd2);
      add_pixel(8'd0, 24'd0, 11'd0, 11'd0, 8'h00, 1'b0, 1'b1, 16'd0);
      add_byte(8'd2);
      add_byte(8'd2);
      add_pixel(8'hC3, 24'd2, 11'd2, 11'd0, 8'hC3, 1'b0, 1'b0, 16'd1);
      add_pixel(8'h3C, 24'd0, 11'd0, 11'd0, 8'h3C, 1'b0, 1'b1, 16'd1);
      add_byte(8'd0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_rows[i]) begin
         if (stim_rows[i].kind == ROW_CSR) begin
            if (dirty) begin
               settle();
               dirty = 1'b0;
            end
            write_csr(stim_rows[i].index, stim_rows[i].value);
         end else begin
            send_byte(stim_rows[i].data, stim_rows[i].typed, stim_rows[i].pixel);
            dirty = 1'b1;
         end
      end

      // Random phases. They cover small frames, a one-pixel frame, a single maximal row,
      // a maximal column of width one, a zero width and two random settings. The
      // idling modes rotate among them.
      run_phase(5, 3, 7, 4, 0, 0, 1'b1);
      run_phase(1, 1, 0, 0, STALL_HEAVY, 0, 1'b0);
      run_phase(16, 4, 16, 3, 0, STALL_HEAVY, 1'b0);
      run_phase(4095, 1, 8191, 65535, STALL_LIGHT, STALL_LIGHT, 1'b0);
      run_phase(1, 4095, 8191, 2, 0, 0, 1'b0);
      run_phase(0, 5, 4096, 1, STALL_HEAVY, 0, 1'b0);
      run_phase($urandom_range(1, 40), $urandom_range(1, 12), $urandom_range(0, 8191),
                $urandom_range(1, 6), 0, STALL_HEAVY, 1'b0);
      run_phase($urandom_range(1, 200), $urandom_range(1, 4), $urandom_range(0, 8191),
                $urandom_range(0, 65535), STALL_LIGHT, STALL_LIGHT, 1'b0);

      // Drain, then watch a while longer for stray items.
      settle();
      if (error_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule
